@@ hw/rtl/vrw_pkg.sv @@
// vrw_pkg: shared types and constants for the velocity ramp with command watchdog
// no dependencies; imported by vrw_ramp and the top level
`default_nettype none

package vrw_pkg;

  localparam int unsigned VelW   = 25;  // signed velocity width
  localparam int unsigned MaxW   = 24;  // configured maxima
  localparam int unsigned RampW  = 20;  // acceleration register
  localparam int unsigned TimeW  = 16;  // timeout and elapsed ms
  localparam int unsigned IdleW  = 17;  // idle counter, holds 65536
  localparam int unsigned StepW  = 25;  // saturated ramp step
  localparam int unsigned ProdW  = RampW + TimeW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 24;

  localparam logic [MaxW-1:0]  VelLimit = MaxW'(10000000);
  localparam logic [IdleW-1:0] IdleSat  = IdleW'(65536);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMaxLinear = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxTurn   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRampRate  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 2'd3;

  // configuration reset values
  localparam logic [MaxW-1:0]  RstMaxLinear = MaxW'(500000);
  localparam logic [MaxW-1:0]  RstMaxTurn   = MaxW'(1000000);
  localparam logic [RampW-1:0] RstRampRate  = RampW'(1000);
  localparam logic [TimeW-1:0] RstTimeout   = TimeW'(500);

  typedef enum logic [1:0] {
    OpCommand = 2'd0,
    OpTick    = 2'd1,
    OpReset   = 2'd2
  } opcode_e;

  // motion codes
  localparam logic [2:0] MotionStop     = 3'd0;
  localparam logic [2:0] MotionForward  = 3'd1;
  localparam logic [2:0] MotionBackward = 3'd2;
  localparam logic [2:0] MotionLeft     = 3'd3;
  localparam logic [2:0] MotionRight    = 3'd4;

endpackage

`default_nettype wire

@@ hw/rtl/velocity_ramp_with_command_watchdog.sv @@
// an accepted tick item gives its result via the input stage, then the result stage
// one item per cycle while no tick stalls; command, reset and unused items give no result
// the ramp step (ramp rate times elapsed ms) is multiplied in the input stage
// a full result register that is not taken stalls only a tick waiting behind it
// rst_ni clears all motion state and restores the configuration reset values
`default_nettype none

module velocity_ramp_with_command_watchdog
  import vrw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDatW-1:0]     cfg_wdata_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             opcode_i,
  input  logic [2:0]             motion_code_i,
  input  logic [TimeW-1:0]       elapsed_ms_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [VelW-1:0] linear_speed_o,
  output logic signed [VelW-1:0] turn_rate_o,
  output logic                   forced_stop_o
);

  // configuration registers
  logic [MaxW-1:0]  max_lin_q, max_turn_q;
  logic [RampW-1:0] ramp_rate_q;
  logic [TimeW-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_lin_q   <= RstMaxLinear;
      max_turn_q  <= RstMaxTurn;
      ramp_rate_q <= RstRampRate;
      timeout_q   <= RstTimeout;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxLinear: max_lin_q   <= cfg_wdata_i[MaxW-1:0];
        CfgMaxTurn:   max_turn_q  <= cfg_wdata_i[MaxW-1:0];
        CfgRampRate:  ramp_rate_q <= cfg_wdata_i[RampW-1:0];
        CfgTimeout:   timeout_q   <= cfg_wdata_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic in_acc;
  logic out_free;
  logic s1_adv;
  logic s1_tick;
  logic res_load;

  // input stage
  logic             s1_valid_q;
  logic [1:0]       s1_op_q;
  logic [2:0]       s1_code_q;
  logic [TimeW-1:0] s1_dt_q;
  logic [StepW-1:0] s1_step_q;

  // elapsed zero counts as one ms
  logic [TimeW-1:0] dt_eff;
  logic [ProdW-1:0] step_prod;
  logic [StepW-1:0] step_d;

  always_comb begin
    dt_eff    = (elapsed_ms_i == '0) ? TimeW'(1) : elapsed_ms_i;
    step_prod = ProdW'(ramp_rate_q) * ProdW'(dt_eff);
    // any step at or beyond 2^25 exceeds every possible velocity gap
    step_d    = (|step_prod[ProdW-1:StepW]) ? '1 : step_prod[StepW-1:0];
  end

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_tick    = (s1_op_q == OpTick);
  assign s1_adv     = s1_valid_q && (!s1_tick || out_free);
  assign res_load   = s1_adv && s1_tick;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= opcode_i;
      s1_code_q <= motion_code_i;
      s1_dt_q   <= dt_eff;
      s1_step_q <= step_d;
    end
  end

  // motion state
  logic [2:0]            active_q, active_d;
  logic signed [VelW-1:0] lin_q, lin_d;
  logic signed [VelW-1:0] ang_q, ang_d;
  logic [IdleW-1:0]      idle_q, idle_d;

  // tick datapath
  logic [IdleW:0]         idle_sum;
  logic [IdleW-1:0]       idle_new;
  logic                   trip;
  logic [2:0]             motion_eff;
  logic [MaxW-1:0]        lin_mag, ang_mag;
  logic signed [VelW-1:0] tgt_lin, tgt_ang;
  logic signed [VelW-1:0] lin_next, ang_next;

  always_comb begin
    idle_sum = {1'b0, idle_q} + (IdleW+1)'(s1_dt_q);
    idle_new = (idle_sum > {1'b0, IdleSat}) ? IdleSat : idle_sum[IdleW-1:0];
    // watchdog trips only on a command other than stop
    trip     = (idle_new > IdleW'(timeout_q)) && (active_q != MotionStop);
    motion_eff = trip ? MotionStop : active_q;

    lin_mag = (max_lin_q > VelLimit) ? VelLimit : max_lin_q;
    ang_mag = (max_turn_q > VelLimit) ? VelLimit : max_turn_q;

    tgt_lin = '0;
    tgt_ang = '0;
    case (motion_eff)
      MotionForward:  tgt_lin = $signed({1'b0, lin_mag});
      MotionBackward: tgt_lin = -$signed({1'b0, lin_mag});
      MotionLeft:     tgt_ang = $signed({1'b0, ang_mag});
      MotionRight:    tgt_ang = -$signed({1'b0, ang_mag});
      default: ;  // stop and undefined codes aim at zero
    endcase
  end

  vrw_ramp u_ramp_lin (
    .now_i    (lin_q),
    .target_i (tgt_lin),
    .step_i   (s1_step_q),
    .next_o   (lin_next)
  );

  vrw_ramp u_ramp_ang (
    .now_i    (ang_q),
    .target_i (tgt_ang),
    .step_i   (s1_step_q),
    .next_o   (ang_next)
  );

  // state update per item kind
  always_comb begin
    active_d = active_q;
    lin_d    = lin_q;
    ang_d    = ang_q;
    idle_d   = idle_q;
    if (s1_adv) begin
      case (s1_op_q)
        OpCommand: begin
          active_d = s1_code_q;
          idle_d   = '0;
        end
        OpTick: begin
          active_d = motion_eff;
          lin_d    = lin_next;
          ang_d    = ang_next;
          idle_d   = idle_new;
        end
        OpReset: begin
          active_d = MotionStop;
          lin_d    = '0;
          ang_d    = '0;
          idle_d   = '0;
        end
        default: ;  // unused opcode leaves everything alone
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= MotionStop;
      lin_q    <= '0;
      ang_q    <= '0;
      idle_q   <= '0;
    end else begin
      active_q <= active_d;
      lin_q    <= lin_d;
      ang_q    <= ang_d;
      idle_q   <= idle_d;
    end
  end

  // result register
  logic out_valid_q, out_valid_d;

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      linear_speed_o <= lin_next;
      turn_rate_o    <= ang_next;
      forced_stop_o  <= trip;
    end
  end

  assign out_valid_o = out_valid_q;

  // a forced stop leaves the stored command at stop
  a_trip_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && trip |=> active_q == MotionStop)
    else $error("forced stop did not clear the command");

  // a tick leaving the input stage always shows up as a result
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_o)
    else $error("tick result lost");

  // velocities stay inside the saturation range
  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lin_q <= $signed({1'b0, VelLimit}) && lin_q >= -$signed({1'b0, VelLimit}) &&
    ang_q <= $signed({1'b0, VelLimit}) && ang_q >= -$signed({1'b0, VelLimit}))
    else $error("velocity out of range");

  // idle counter never passes its saturation value
  a_idle_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q <= IdleSat)
    else $error("idle counter overflow");

endmodule

`default_nettype wire

@@ hw/rtl/vrw_ramp.sv @@
// vrw_ramp: moves one velocity toward its target by at most one step
// depends on vrw_pkg
`default_nettype none

module vrw_ramp
  import vrw_pkg::*;
(
  input  logic signed [VelW-1:0]  now_i,
  input  logic signed [VelW-1:0]  target_i,
  input  logic        [StepW-1:0] step_i,
  output logic signed [VelW-1:0]  next_o
);

  logic signed [VelW:0] diff;
  logic        [VelW:0] mag;
  logic signed [VelW:0] moved;

  always_comb begin
    diff  = {target_i[VelW-1], target_i} - {now_i[VelW-1], now_i};
    mag   = diff[VelW] ? (VelW+1)'(-diff) : (VelW+1)'(diff);
    if (diff[VelW]) begin
      moved = {now_i[VelW-1], now_i} - $signed({1'b0, step_i});
    end else begin
      moved = {now_i[VelW-1], now_i} + $signed({1'b0, step_i});
    end
    // snap when within one step
    if (mag <= {1'b0, step_i}) begin
      next_o = target_i;
    end else begin
      next_o = moved[VelW-1:0];
    end
  end

endmodule

`default_nettype wire
